/* src/rdc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdc_pkg
// Shared types and constants of the reliable datagram channel header engine.
// ----------------------------------------------------------------------------
package rdc_pkg;

  localparam int unsigned SeqW   = 30;
  localparam int unsigned LenW   = 16;
  localparam int unsigned MplW   = 13;

  // Bytes that the fragment buffers hold.
  localparam logic [LenW:0] FragCap = 17'd16384;

  localparam logic [MplW-1:0] MplReset = 13'd1390;

  localparam int unsigned InDataW  = 120;
  localparam int unsigned OutDataW = 184;

  typedef enum logic {
    OP_RX = 1'b0,
    OP_TX = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_STALE        = 3'd1,
    ST_FRAG_ORDER   = 3'd2,
    ST_FRAG_MISSING = 3'd3,
    ST_OVERSIZE     = 3'd4,
    ST_HELD         = 3'd5,
    ST_FATAL        = 3'd6,
    ST_DUMPED       = 3'd7
  } status_e;

  typedef struct packed {
    op_e              op;
    logic [31:0]      seq_word;
    logic [31:0]      ack_word;
    logic [15:0]      frag_word;
    logic [LenW-1:0]  payload_length;
    logic [LenW-1:0]  pending_message_length;
    logic             message_overflowed;
  } in_item_t;

  typedef struct packed {
    logic             accepted;
    status_e          status;
    logic [SeqW-1:0]  lost_packets;
    logic [LenW-1:0]  assembled_length;
    logic [31:0]      header_word1;
    logic [31:0]      header_word2;
    logic [15:0]      fragment_word;
    logic             has_fragment_word;
    logic [LenW-1:0]  reliable_bytes;
    logic [LenW-1:0]  chunk_offset;
    logic [LenW-1:0]  chunk_length;
    logic             message_taken;
  } result_t;

endpackage

/* src/reliable_datagram_channel_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reliable_datagram_channel_top
// Header engine of a sequenced datagram channel with a reliable message bit.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake          Contents
//   s_axis    in         tvalid/tready      one rx header or tx request item
//   m_axis    out        tvalid/tready      one result item per input item
//   cfg       in         cfg_we_i           max_packet_length register write
//
// Each result is offered once its item has passed the input register, where
// the header logic works on it, and has been taken into the result register,
// which waits while a stalled consumer holds the previous result. A new item
// can be accepted every cycle while the consumer does not stall; the throughput
// is set by the single state update per item, which completes in the cycle the
// item leaves the input register. When the result register is held by a stalled
// consumer, one more item can wait in the input register. Reset clears all
// channel state, sets the outgoing sequence to one and max_packet_length to 1390.
//
module reliable_datagram_channel_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Configuration: max_packet_length.
  input  logic                            cfg_we_i,
  input  logic [rdc_pkg::MplW-1:0]        cfg_wdata_i,
  // Input items.
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // From bit 0: seq_word, ack_word, frag_word, payload_length,
  // pending_message_length, message_overflowed, zero fill.
  input  logic [rdc_pkg::InDataW-1:0]     s_axis_tdata_i,
  // Bit 0: op.
  input  logic                            s_axis_tuser_i,
  // Result items.
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // From bit 0: accepted, status, lost_packets, assembled_length,
  // header_word1, header_word2, fragment_word, has_fragment_word,
  // reliable_bytes, chunk_offset, chunk_length, message_taken, zero fill.
  output logic [rdc_pkg::OutDataW-1:0]    m_axis_tdata_o
);
  import rdc_pkg::*;

  logic     s1_valid_q;
  in_item_t s1_item_q;
  in_item_t in_item;
  logic     out_valid_q;
  result_t  out_res_q;
  result_t  res;
  logic     out_free;
  logic     fire;

  // The result register can take a new result when empty or being drained.
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign fire            = s1_valid_q && out_free;
  assign s_axis_tready_o = !s1_valid_q || out_free;

  assign in_item.op                     = op_e'(s_axis_tuser_i);
  assign in_item.seq_word               = s_axis_tdata_i[31:0];
  assign in_item.ack_word               = s_axis_tdata_i[63:32];
  assign in_item.frag_word              = s_axis_tdata_i[79:64];
  assign in_item.payload_length         = s_axis_tdata_i[95:80];
  assign in_item.pending_message_length = s_axis_tdata_i[111:96];
  assign in_item.message_overflowed     = s_axis_tdata_i[112];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      s1_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      s1_item_q <= in_item;
    end
  end

  // The header logic and channel state; state advances only on fire.
  rdc_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .fire_i      (fire),
    .item_i      (s1_item_q),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'b0000,
                            out_res_q.message_taken,
                            out_res_q.chunk_length,
                            out_res_q.chunk_offset,
                            out_res_q.reliable_bytes,
                            out_res_q.has_fragment_word,
                            out_res_q.fragment_word,
                            out_res_q.header_word2,
                            out_res_q.header_word1,
                            out_res_q.assembled_length,
                            out_res_q.lost_packets,
                            out_res_q.status,
                            out_res_q.accepted};

`ifndef NO_ASSERTIONS
  a_fire_fills_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> m_axis_tvalid_o)
    else $error("processed item produced no result");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> s_axis_tready_o)
    else $error("input not ready while input register is empty");

  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |-> !fire)
    else $error("result overwritten while stalled");
`endif

endmodule

/* src/rdc_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdc_core
// Channel state and the single-pass receive and transmit header logic.
// ----------------------------------------------------------------------------
module rdc_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rdc_pkg::MplW-1:0]      cfg_wdata_i,
  input  logic                          fire_i,
  input  rdc_pkg::in_item_t             item_i,
  output rdc_pkg::result_t              res_o
);
  import rdc_pkg::*;

  logic [MplW-1:0] mpl_q;
  logic [SeqW-1:0] inc_seq_q, inc_seq_d;
  logic [SeqW-1:0] inc_ack_q, inc_ack_d;
  logic            inc_rel_q, inc_rel_d;
  logic            rem_ack_q, rem_ack_d;
  logic            out_rel_q, out_rel_d;
  logic [LenW-1:0] rel_len_q, rel_len_d;
  logic [SeqW-1:0] last_rel_q, last_rel_d;
  logic [SeqW-1:0] out_seq_q, out_seq_d;
  logic [SeqW-1:0] rasm_seq_q, rasm_seq_d;
  logic [LenW-1:0] rasm_size_q, rasm_size_d;
  logic [LenW-1:0] sf_size_q, sf_size_d;
  logic [LenW-1:0] sf_read_q, sf_read_d;
  logic            frag_pend_q, frag_pend_d;

  always_comb begin
    logic [SeqW-1:0] seq;
    logic [LenW-1:0] len;
    logic [LenW-1:0] rsize_eff;
    logic [LenW:0]   rsum;
    logic [14:0]     off;
    logic [LenW-1:0] rel_eff;
    logic            take;
    logic            send_rel;
    logic            splitting;
    logic [LenW-1:0] fsize0;
    logic [LenW-1:0] fsize1;
    logic            fits;
    logic [LenW-1:0] nf_size;
    logic [LenW-1:0] nf_read;
    logic            nf_rel;
    logic [LenW-1:0] remain;
    logic [LenW-1:0] flen;
    logic [LenW:0]   fsum;
    logic            more;
    logic [LenW-1:0] mpl_ext;

    res_o       = '0;
    inc_seq_d   = inc_seq_q;
    inc_ack_d   = inc_ack_q;
    inc_rel_d   = inc_rel_q;
    rem_ack_d   = rem_ack_q;
    out_rel_d   = out_rel_q;
    rel_len_d   = rel_len_q;
    last_rel_d  = last_rel_q;
    out_seq_d   = out_seq_q;
    rasm_seq_d  = rasm_seq_q;
    rasm_size_d = rasm_size_q;
    sf_size_d   = sf_size_q;
    sf_read_d   = sf_read_q;
    frag_pend_d = frag_pend_q;

    seq     = item_i.seq_word[SeqW-1:0];
    len     = item_i.payload_length;
    off     = item_i.frag_word[14:0];
    mpl_ext = {{(LenW-MplW){1'b0}}, mpl_q};

    // Receive reassembly.
    rsize_eff = (rasm_seq_q != seq) ? '0 : rasm_size_q;
    rsum      = {1'b0, rsize_eff} + {1'b0, len};

    // Transmit: reliable resend or latch of the pending message.
    take     = (rel_len_q == '0) && (item_i.pending_message_length != '0);
    rel_eff  = take ? item_i.pending_message_length : rel_len_q;
    send_rel = take || ((inc_ack_q > last_rel_q) && (rem_ack_q != out_rel_q));
    splitting = (len > mpl_ext) ||
                (send_rel && (({1'b0, rel_eff} + {1'b0, len}) > {1'b0, mpl_ext}));
    if (send_rel) begin
      fsize0 = ({1'b0, rel_eff} > FragCap) ? FragCap[LenW-1:0] : rel_eff;
    end else begin
      fsize0 = sf_size_q;
    end
    fits   = ({1'b0, fsize0} > FragCap) || ((FragCap - {1'b0, fsize0}) >= {1'b0, len});
    fsize1 = fits ? (fsize0 + len) : fsize0;

    // Next fragment, either continuing a split packet or starting one.
    if (frag_pend_q) begin
      nf_size = sf_size_q;
      nf_read = sf_read_q;
      nf_rel  = (rel_len_q != '0);
    end else begin
      nf_size = fsize1;
      nf_read = '0;
      nf_rel  = (rel_eff != '0);
    end
    remain = (nf_size > nf_read) ? (nf_size - nf_read) : '0;
    flen   = (remain > mpl_ext) ? mpl_ext : remain;
    fsum   = {1'b0, nf_read} + {1'b0, flen};
    more   = (fsum != {1'b0, nf_size});

    if (item_i.op == OP_RX) begin
      if (seq <= inc_seq_q) begin
        res_o.status = ST_STALE;
      end else begin
        res_o.lost_packets = seq - inc_seq_q - 1'b1;
        rem_ack_d = item_i.ack_word[31];
        if (item_i.ack_word[31] == out_rel_q) begin
          rel_len_d = '0;
        end
        res_o.assembled_length = len;
        if (item_i.seq_word[30]) begin
          rasm_seq_d  = seq;
          rasm_size_d = rsize_eff;
          res_o.assembled_length = '0;
          priority if ({1'b0, off} < rsize_eff) begin
            res_o.status = ST_FRAG_ORDER;
          end else if ({1'b0, off} > rsize_eff) begin
            res_o.status = ST_FRAG_MISSING;
          end else if (rsum > FragCap) begin
            res_o.status = ST_OVERSIZE;
          end else if (item_i.frag_word[15]) begin
            rasm_size_d  = rsum[LenW-1:0];
            res_o.status = ST_HELD;
          end else begin
            rasm_size_d = '0;
            res_o.assembled_length = rsum[LenW-1:0];
          end
        end
        if (res_o.status == ST_OK) begin
          inc_seq_d      = seq;
          inc_ack_d      = item_i.ack_word[SeqW-1:0];
          inc_rel_d      = inc_rel_q ^ item_i.seq_word[31];
          res_o.accepted = 1'b1;
        end
      end
    end else begin
      if (item_i.message_overflowed) begin
        res_o.status = ST_FATAL;
      end else if (frag_pend_q || splitting) begin
        if (!frag_pend_q) begin
          rel_len_d = rel_eff;
          if (take) begin
            out_rel_d           = ~out_rel_q;
            res_o.message_taken = 1'b1;
          end
          if (send_rel) begin
            last_rel_d = out_seq_q;
          end
          if (!fits) begin
            res_o.status = ST_DUMPED;
          end
        end
        res_o.accepted          = 1'b1;
        res_o.header_word1      = {nf_rel, 1'b1, out_seq_q};
        res_o.header_word2      = {inc_rel_q, 1'b0, inc_seq_q};
        res_o.fragment_word     = {more, nf_read[14:0]};
        res_o.has_fragment_word = 1'b1;
        res_o.chunk_offset      = nf_read;
        res_o.chunk_length      = flen;
        frag_pend_d = more;
        if (more) begin
          sf_size_d = nf_size;
          sf_read_d = fsum[LenW-1:0];
        end else begin
          out_seq_d = out_seq_q + 1'b1;
          sf_size_d = '0;
          sf_read_d = '0;
        end
      end else begin
        rel_len_d = rel_eff;
        if (take) begin
          out_rel_d           = ~out_rel_q;
          res_o.message_taken = 1'b1;
        end
        res_o.accepted     = 1'b1;
        res_o.header_word1 = {send_rel, 1'b0, out_seq_q};
        res_o.header_word2 = {inc_rel_q, 1'b0, inc_seq_q};
        if (send_rel) begin
          last_rel_d           = out_seq_q;
          res_o.reliable_bytes = rel_eff;
        end
        res_o.chunk_length = len;
        out_seq_d = out_seq_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mpl_q <= MplReset;
    end else if (cfg_we_i) begin
      mpl_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inc_seq_q   <= '0;
      inc_ack_q   <= '0;
      inc_rel_q   <= 1'b0;
      rem_ack_q   <= 1'b0;
      out_rel_q   <= 1'b0;
      rel_len_q   <= '0;
      last_rel_q  <= '0;
      out_seq_q   <= {{(SeqW-1){1'b0}}, 1'b1};
      rasm_seq_q  <= '0;
      rasm_size_q <= '0;
      sf_size_q   <= '0;
      sf_read_q   <= '0;
      frag_pend_q <= 1'b0;
    end else if (fire_i) begin
      inc_seq_q   <= inc_seq_d;
      inc_ack_q   <= inc_ack_d;
      inc_rel_q   <= inc_rel_d;
      rem_ack_q   <= rem_ack_d;
      out_rel_q   <= out_rel_d;
      rel_len_q   <= rel_len_d;
      last_rel_q  <= last_rel_d;
      out_seq_q   <= out_seq_d;
      rasm_seq_q  <= rasm_seq_d;
      rasm_size_q <= rasm_size_d;
      sf_size_q   <= sf_size_d;
      sf_read_q   <= sf_read_d;
      frag_pend_q <= frag_pend_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_read_within_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sf_read_q <= sf_size_q)
    else $error("fragment read position beyond fragment size");

  a_idle_split_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !frag_pend_q |-> (sf_size_q == '0) && (sf_read_q == '0))
    else $error("split state left over with no fragment pending");

  a_rasm_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, rasm_size_q} <= FragCap)
    else $error("reassembly size beyond buffer capacity");

  a_rx_accept_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && (item_i.op == OP_RX) && res_o.accepted
    |=> inc_seq_q == $past(item_i.seq_word[SeqW-1:0]))
    else $error("accepted packet did not advance incoming sequence");
`endif

endmodule
